// ===== hw/rtl/sfpd_pkg.sv =====
// Shared types and constants for the sync-framed packet deframer.
// Holds the configuration bundle, the result bundle and the state codes.
// No dependencies.
`timescale 1ns / 1ps

package sfpd_pkg;

    // Header is sync1, sync2, type, length high, length low.
    localparam int unsigned HEADER_BYTES = 5;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_NONE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_SUM8   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_SUM16  = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [7:0]  RST_SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  RST_SYNC_SECOND = 8'h55;
    localparam logic [15:0] RST_MIN_LEN     = 16'd6;
    localparam logic [15:0] RST_MAX_LEN     = 16'd1023;
    localparam logic [3:0]  RST_CODE_NONE   = 4'd0;
    localparam logic [3:0]  RST_CODE_SUM8   = 4'd1;
    localparam logic [3:0]  RST_CODE_SUM16  = 4'd2;

    // Byte positions within the header, counting the syncs.
    localparam logic [15:0] POS_TYPE   = 16'd3;
    localparam logic [15:0] POS_LEN_HI = 16'd4;
    localparam logic [15:0] POS_LEN_LO = 16'(HEADER_BYTES);

    // Smallest lengths that hold the header, the check and at least one byte past the header.
    localparam logic [15:0] NEED_SHORT = 16'(HEADER_BYTES + 1);
    localparam logic [15:0] NEED_SUM16 = 16'(HEADER_BYTES + 2);

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_SYNC1  = 2'd1,
        PH_PACKET = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CK_NONE    = 2'd0,
        CK_SUM8    = 2'd1,
        CK_SUM16   = 2'd2,
        CK_UNKNOWN = 2'd3
    } check_kind_t;

    typedef struct packed {
        logic [7:0]  sync_first_byte;
        logic [7:0]  sync_second_byte;
        logic [15:0] min_packet_len;
        logic [15:0] max_packet_len;
        logic [3:0]  code_no_check;
        logic [3:0]  code_sum8;
        logic [3:0]  code_sum16;
    } cfg_t;

    typedef struct packed {
        logic        payload_present;
        logic [7:0]  payload_byte;
        logic        end_of_packet;
        logic        packet_good;
        logic [15:0] message_len;
    } result_t;

endpackage

// ===== hw/rtl/sfpd_cfg_regs.sv =====
// Configuration register file of the deframer.
// Depends on sfpd_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module sfpd_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [sfpd_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [sfpd_pkg::CFG_DATA_W-1:0] wr_data,
    output sfpd_pkg::cfg_t                 cfg
);
    import sfpd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; an index past the list changes nothing.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_SYNC_FIRST:  cfg_next.sync_first_byte  = wr_data[7:0];
                REG_SYNC_SECOND: cfg_next.sync_second_byte = wr_data[7:0];
                REG_MIN_LEN:     cfg_next.min_packet_len   = wr_data;
                REG_MAX_LEN:     cfg_next.max_packet_len   = wr_data;
                REG_CODE_NONE:   cfg_next.code_no_check    = wr_data[3:0];
                REG_CODE_SUM8:   cfg_next.code_sum8        = wr_data[3:0];
                REG_CODE_SUM16:  cfg_next.code_sum16       = wr_data[3:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first_byte  <= RST_SYNC_FIRST;
            cfg_reg.sync_second_byte <= RST_SYNC_SECOND;
            cfg_reg.min_packet_len   <= RST_MIN_LEN;
            cfg_reg.max_packet_len   <= RST_MAX_LEN;
            cfg_reg.code_no_check    <= RST_CODE_NONE;
            cfg_reg.code_sum8        <= RST_CODE_SUM8;
            cfg_reg.code_sum16       <= RST_CODE_SUM16;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/sfpd_core.sv =====
// Framing state and per-byte step logic of the deframer.
// Depends on sfpd_pkg for phase_t, check_kind_t, cfg_t and result_t.
`timescale 1ns / 1ps

module sfpd_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [7:0]        rx_byte,
    input  sfpd_pkg::cfg_t    cfg,
    output logic              res_valid,
    output sfpd_pkg::result_t res
);
    import sfpd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic        hdr_done_reg, hdr_done_next;
    logic [15:0] exp_len_reg, exp_len_next;
    check_kind_t kind_reg, kind_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] sum_reg, sum_next;
    logic [15:0] rx_check_reg, rx_check_next;

    logic [15:0] count_inc;
    logic [15:0] pkt_len;
    logic [15:0] need_len;
    logic [1:0]  check_len;
    logic [15:0] data_end;
    logic [15:0] sum_add;
    logic [15:0] sum_fin;
    logic [15:0] check_fin;
    logic        is_sync1;
    logic        is_sync2;
    logic        hdr_bad;
    logic        in_data;
    logic        at_end;
    logic        drop;

    // Shared terms of the step.
    always_comb begin
        count_inc = count_reg + 16'd1;
        pkt_len   = {len_hi_reg, rx_byte};
        sum_add   = sum_reg + {8'd0, rx_byte};
        is_sync1  = (rx_byte == cfg.sync_first_byte);
        is_sync2  = (rx_byte == cfg.sync_second_byte);
        case (kind_reg)
            CK_SUM8:  check_len = 2'd1;
            CK_SUM16: check_len = 2'd2;
            default:  check_len = 2'd0;
        endcase
        need_len = (kind_reg == CK_SUM16) ? NEED_SUM16 : NEED_SHORT;
        hdr_bad  = (kind_reg == CK_UNKNOWN) || (pkt_len < cfg.min_packet_len)
                   || (pkt_len > cfg.max_packet_len) || (pkt_len < need_len);
        data_end = exp_len_reg - {14'd0, check_len};
        in_data  = (phase_reg == PH_PACKET) && hdr_done_reg && (count_inc <= data_end);
        at_end   = (phase_reg == PH_PACKET) && hdr_done_reg && (count_inc >= exp_len_reg);
        // Running sum and received check after this byte, before any clearing.
        sum_fin   = in_data ? sum_add : sum_reg;
        check_fin = in_data ? rx_check_reg : {rx_check_reg[7:0], rx_byte};
    end

    // Framing phase.
    always_comb begin
        phase_next = phase_reg;
        drop       = 1'b0;
        unique case (phase_reg)
            PH_HUNT, PH_SYNC1: begin
                if (is_sync1) begin
                    phase_next = PH_SYNC1;
                end else if (phase_reg == PH_SYNC1 && is_sync2) begin
                    phase_next = PH_PACKET;
                end else begin
                    phase_next = PH_HUNT;
                    drop       = 1'b1;
                end
            end
            PH_PACKET: begin
                if (!hdr_done_reg) begin
                    if (count_inc == POS_LEN_LO) begin
                        drop = hdr_bad;
                    end else if (count_inc != POS_TYPE && count_inc != POS_LEN_HI) begin
                        drop = 1'b1;
                    end
                end else if (at_end) begin
                    drop = 1'b1;
                end
                if (drop) begin
                    phase_next = PH_HUNT;
                end
            end
            default: begin
                phase_next = PH_HUNT;
                drop       = 1'b1;
            end
        endcase
    end

    // Counters, header fields, sums and the result of the step.
    always_comb begin
        count_next    = count_reg;
        hdr_done_next = hdr_done_reg;
        exp_len_next  = exp_len_reg;
        kind_next     = kind_reg;
        len_hi_next   = len_hi_reg;
        sum_next      = sum_reg;
        rx_check_next = rx_check_reg;

        if (phase_reg != PH_PACKET) begin
            if (is_sync1) begin
                count_next = 16'd1;
            end else if (phase_reg == PH_SYNC1 && is_sync2) begin
                count_next = 16'd2;
            end
        end else begin
            count_next = count_inc;
            if (!hdr_done_reg) begin
                if (count_inc == POS_TYPE) begin
                    sum_next = {8'd0, rx_byte};
                    if (rx_byte[7:4] == cfg.code_no_check) begin
                        kind_next = CK_NONE;
                    end else if (rx_byte[7:4] == cfg.code_sum8) begin
                        kind_next = CK_SUM8;
                    end else if (rx_byte[7:4] == cfg.code_sum16) begin
                        kind_next = CK_SUM16;
                    end else begin
                        kind_next = CK_UNKNOWN;
                    end
                end else if (count_inc == POS_LEN_HI) begin
                    len_hi_next = rx_byte;
                    sum_next    = sum_add;
                end else if (count_inc == POS_LEN_LO) begin
                    sum_next      = sum_add;
                    exp_len_next  = pkt_len;
                    hdr_done_next = 1'b1;
                end
            end else if (in_data) begin
                sum_next = sum_add;
            end else begin
                rx_check_next = {rx_check_reg[7:0], rx_byte};
            end
        end

        // A dropped or finished packet leaves everything cleared.
        if (drop) begin
            count_next    = 16'd0;
            hdr_done_next = 1'b0;
            exp_len_next  = 16'd0;
            kind_next     = CK_NONE;
            len_hi_next   = 8'd0;
            sum_next      = 16'd0;
            rx_check_next = 16'd0;
        end

        // The check compares against the sums as they stand after this byte.
        res_valid           = in_data || at_end;
        res.payload_present = in_data;
        res.payload_byte    = in_data ? rx_byte : 8'd0;
        res.end_of_packet   = at_end;
        res.packet_good     = 1'b0;
        res.message_len     = 16'd0;
        if (at_end) begin
            case (kind_reg)
                CK_SUM8:  res.packet_good = (sum_fin[7:0] == check_fin[7:0]);
                CK_SUM16: res.packet_good = (sum_fin == check_fin);
                default:  res.packet_good = 1'b1;
            endcase
            res.message_len = data_end - 16'(HEADER_BYTES);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT;
            count_reg    <= 16'd0;
            hdr_done_reg <= 1'b0;
            exp_len_reg  <= 16'd0;
            kind_reg     <= CK_NONE;
            len_hi_reg   <= 8'd0;
            sum_reg      <= 16'd0;
            rx_check_reg <= 16'd0;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            hdr_done_reg <= hdr_done_next;
            exp_len_reg  <= exp_len_next;
            kind_reg     <= kind_next;
            len_hi_reg   <= len_hi_next;
            sum_reg      <= sum_next;
            rx_check_reg <= rx_check_next;
        end
    end

endmodule

// ===== hw/rtl/sync_framed_packet_deframer.sv =====
// Top level of the sync-framed packet deframer: input register, step core,
// result register and configuration registers.
// Depends on sfpd_pkg, sfpd_cfg_regs and sfpd_core.
//
//  Channel   Direction  Carries
//  s_        in         one received byte per item
//  m_        out        payload byte and/or end-of-packet status per item
//  cfg_      in         register index and write data
//
// Each byte is held in the input register, stepped through the framing
// logic, and any result lands in the output register. One byte per cycle
// is sustained unless m_tready stalls the output. Header bytes and
// dropped bytes produce no output item. A stall on m_tready holds both
// stages; s_tready drops only when the input register cannot move on.
// Reset (aresetn low, synchronous) empties both stages and restores the
// register defaults.
`timescale 1ns / 1ps

module sync_framed_packet_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    // Input byte stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] payload_byte, [23:8] message_len
    output logic        m_tlast,    // end_of_packet
    output logic [1:0]  m_tuser,    // [0] payload_present, [1] packet_good
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import sfpd_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_res_reg;

    logic       advance;
    logic       step_en;
    logic       res_valid;
    result_t    res;
    cfg_t       cfg;

    // Configuration is always taken.
    assign cfg_ready = 1'b1;

    sfpd_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The held byte steps when the result register is free or draining.
    assign advance  = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    sfpd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Stage occupancy.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = step_en && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
        if (step_en && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.message_len, out_res_reg.payload_byte};
    assign m_tlast  = out_res_reg.end_of_packet;
    assign m_tuser  = {out_res_reg.packet_good, out_res_reg.payload_present};

endmodule

// ===== tb/sfpd_deframe_checker.sv =====
// Result checker for the sync-framed packet deframer: follows every accepted byte and
// register write, predicts the output items and compares them as they leave the block.
// Depends on sfpd_pkg.
`timescale 1ns / 1ps

module sfpd_deframe_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // [7:0] payload_byte, [23:8] message_len
    input  logic        m_tlast,    // end_of_packet
    input  logic [1:0]  m_tuser,    // [0] payload_present, [1] packet_good
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          results_due
);
    import sfpd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Shadow of the register file and of the framing state.
    cfg_t        regs;
    phase_t      phase;
    logic [15:0] count;
    logic        hdr_done;
    logic [15:0] frame_len;
    check_kind_t kind;
    logic [7:0]  len_hi;
    logic [15:0] sum;
    logic [15:0] rx_check;

    // Output items still owed by the block, oldest first.
    result_t     owed_q[$];

    initial begin
        fail_count  = 0;
        results_due = 0;
    end

    function automatic int unsigned check_len(input check_kind_t k);
        if (k == CK_SUM8) return 1;
        if (k == CK_SUM16) return 2;
        return 0;
    endfunction

    // Back to hunting for the first sync byte.
    function automatic void clear_frame();
        phase     = PH_HUNT;
        count     = '0;
        hdr_done  = 1'b0;
        frame_len = '0;
        kind      = CK_NONE;
        len_hi    = '0;
        sum       = '0;
        rx_check  = '0;
    endfunction

    function automatic void load_reg(input logic [2:0] idx, input logic [15:0] d);
        case (idx)
            REG_SYNC_FIRST:  regs.sync_first_byte  = d[7:0];
            REG_SYNC_SECOND: regs.sync_second_byte = d[7:0];
            REG_MIN_LEN:     regs.min_packet_len   = d;
            REG_MAX_LEN:     regs.max_packet_len   = d;
            REG_CODE_NONE:   regs.code_no_check    = d[3:0];
            REG_CODE_SUM8:   regs.code_sum8        = d[3:0];
            REG_CODE_SUM16:  regs.code_sum16       = d[3:0];
            default: ;
        endcase
    endfunction

    // Advances the framing state by one received byte; returns 1 when the byte
    // gives an output item, which is then left in res.
    function automatic bit deframe_byte(input logic [7:0] b, output result_t res);
        int unsigned ck;
        int unsigned need;
        logic [15:0] len;
        bit          present;
        bit          fin;

        res     = '0;
        present = 1'b0;
        fin     = 1'b0;

        // Sync hunt: a first sync byte always restarts it.
        if (phase != PH_PACKET) begin
            if (b == regs.sync_first_byte) begin
                phase = PH_SYNC1;
                count = 16'd1;
            end else if (phase == PH_SYNC1 && b == regs.sync_second_byte) begin
                phase = PH_PACKET;
                count = 16'd2;
            end else begin
                clear_frame();
            end
            return 1'b0;
        end

        count = count + 16'd1;

        // Type and length bytes; the packet is judged on the last of them.
        if (!hdr_done) begin
            if (count == POS_TYPE) begin
                sum = {8'd0, b};
                if (b[7:4] == regs.code_no_check) kind = CK_NONE;
                else if (b[7:4] == regs.code_sum8) kind = CK_SUM8;
                else if (b[7:4] == regs.code_sum16) kind = CK_SUM16;
                else kind = CK_UNKNOWN;
            end else if (count == POS_LEN_HI) begin
                len_hi = b;
                sum    = sum + b;
            end else if (count == POS_LEN_LO) begin
                len  = {len_hi, b};
                ck   = check_len(kind);
                need = HEADER_BYTES + ((ck > 1) ? ck : 1);
                sum  = sum + b;
                if (kind == CK_UNKNOWN || len < regs.min_packet_len
                        || len > regs.max_packet_len || len < need) begin
                    clear_frame();
                    return 1'b0;
                end
                frame_len = len;
                hdr_done  = 1'b1;
            end else begin
                clear_frame();
            end
            return 1'b0;
        end

        // Payload bytes go into the sum, trailing bytes form the received check.
        ck = check_len(kind);
        if (count <= frame_len - 16'(ck)) begin
            present = 1'b1;
            sum     = sum + b;
        end else begin
            rx_check = {rx_check[7:0], b};
        end

        if (count >= frame_len) begin
            fin               = 1'b1;
            res.end_of_packet = 1'b1;
            if (kind == CK_SUM8) res.packet_good = (sum[7:0] == rx_check[7:0]);
            else if (kind == CK_SUM16) res.packet_good = (sum == rx_check);
            else res.packet_good = 1'b1;
            res.message_len = frame_len - 16'(HEADER_BYTES) - 16'(ck);
            clear_frame();
        end

        if (!present && !fin) return 1'b0;
        res.payload_present = present;
        res.payload_byte    = present ? b : 8'd0;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            if (fail_count < REPORT_LIMIT)
                $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Everything is sampled at the rising edge, before the block's registers move.
    always @(posedge aclk) begin : monitor
        result_t got;
        result_t want;
        result_t nxt;

        if (!aresetn) begin
            regs = '{sync_first_byte: RST_SYNC_FIRST, sync_second_byte: RST_SYNC_SECOND,
                     min_packet_len: RST_MIN_LEN, max_packet_len: RST_MAX_LEN,
                     code_no_check: RST_CODE_NONE, code_sum8: RST_CODE_SUM8,
                     code_sum16: RST_CODE_SUM16};
            clear_frame();
            owed_q.delete();
        end else begin
            // An item leaving now always stems from an earlier byte.
            if (m_tvalid && m_tready) begin
                got.payload_present = m_tuser[0];
                got.payload_byte    = m_tdata[7:0];
                got.end_of_packet   = m_tlast;
                got.packet_good     = m_tuser[1];
                got.message_len     = m_tdata[23:8];
                if (owed_q.size() == 0) begin
                    if (fail_count < REPORT_LIMIT)
                        $display("%0t ns: output item with none expected, tdata %h", $time,
                                 m_tdata);
                    fail_count++;
                end else begin
                    want = owed_q.pop_front();
                    check_field("payload_present", 16'(want.payload_present),
                                16'(got.payload_present));
                    check_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
                    check_field("end_of_packet", 16'(want.end_of_packet),
                                16'(got.end_of_packet));
                    check_field("packet_good", 16'(want.packet_good), 16'(got.packet_good));
                    check_field("message_len", want.message_len, got.message_len);
                end
            end
            if (cfg_valid && cfg_ready)
                load_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready && deframe_byte(s_tdata, nxt))
                owed_q.push_back(nxt);
        end
        results_due = owed_q.size();
    end

endmodule

// ===== tb/sync_framed_packet_deframer_tb.sv =====
// Testbench top for the sync-framed packet deframer: reset, clock, packet stimulus,
// register phases and receiver back-pressure. Depends on sfpd_pkg, the block and
// sfpd_deframe_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module sync_framed_packet_deframer_tb;
    import sfpd_pkg::*;

    // Payload fill patterns.
    localparam int PAY_RANDOM = 0;
    localparam int PAY_ZERO   = 1;
    localparam int PAY_ONES   = 2;
    localparam int PAY_SYNC   = 3;

    // Receiver stall patterns.
    localparam int RX_ALWAYS   = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_SPARSE   = 2;
    localparam int RX_PERIODIC = 3;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_BYTES  = 100;
    localparam int LONG_FRAME    = 120;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          results_due;

    // Register values as last written, used to build packets.
    cfg_t        shadow;
    logic [7:0]  tx_q[$];
    int          burst_left;
    int          hold_req;

    sync_framed_packet_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sfpd_deframe_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    initial begin : watchdog
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: changes pattern every so often and honors long hold-off requests.
    initial begin : rx_side
        int mode;
        int left;
        int holds_done;
        int tick;

        m_tready   = 1'b0;
        mode       = RX_ALWAYS;
        left       = 0;
        holds_done = 0;
        tick       = 0;
        forever begin
            @(negedge aclk);
            if (hold_req != holds_done) begin
                holds_done = hold_req;
                m_tready   = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (left == 0) begin
                mode = $urandom_range(RX_ALWAYS, RX_PERIODIC);
                left = $urandom_range(20, 120);
            end
            left--;
            tick++;
            case (mode)
                RX_ALWAYS:   m_tready = 1'b1;
                RX_COIN:     m_tready = 1'($urandom_range(0, 1));
                RX_SPARSE:   m_tready = ($urandom_range(0, 3) == 0);
                default:     m_tready = (tick % 5 != 4);
            endcase
        end
    end

    // Offers one byte and waits for it to be taken; the sender runs in bursts.
    task automatic send_byte(input logic [7:0] b);
        int gap;

        if (burst_left <= 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(1, 24);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
    endtask

    task automatic send_all();
        while (tx_q.size() > 0)
            send_byte(tx_q.pop_front());
    endtask

    // Stops input and waits until the block has delivered everything and drained.
    task automatic quiesce();
        s_tvalid = 1'b0;
        while (results_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [15:0] d);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        case (idx)
            REG_SYNC_FIRST:  shadow.sync_first_byte  = d[7:0];
            REG_SYNC_SECOND: shadow.sync_second_byte = d[7:0];
            REG_MIN_LEN:     shadow.min_packet_len   = d;
            REG_MAX_LEN:     shadow.max_packet_len   = d;
            REG_CODE_NONE:   shadow.code_no_check    = d[3:0];
            REG_CODE_SUM8:   shadow.code_sum8        = d[3:0];
            REG_CODE_SUM16:  shadow.code_sum16       = d[3:0];
            default: ;
        endcase
    endtask

    // Builds one packet with the current sync values and queues its first keep bytes.
    // A set corrupt flag flips one bit of the check.
    task automatic add_frame(input check_kind_t k, input int unsigned len, input bit corrupt,
                             input int pat, input int unsigned keep);
        logic [7:0]  frame[$];
        logic [15:0] flen;
        logic [15:0] total;
        logic [7:0]  flip;
        logic [7:0]  p;
        logic [7:0]  type_byte;
        logic [3:0]  code;
        int unsigned ck;
        int unsigned n_pay;

        flen = len[15:0];
        flip = corrupt ? 8'(1 << $urandom_range(0, 7)) : 8'd0;
        case (k)
            CK_NONE: begin
                code = shadow.code_no_check;
                ck   = 0;
            end
            CK_SUM8: begin
                code = shadow.code_sum8;
                ck   = 1;
            end
            CK_SUM16: begin
                code = shadow.code_sum16;
                ck   = 2;
            end
            default: begin
                ck   = 0;
                code = 4'($urandom);
                while (code == shadow.code_no_check || code == shadow.code_sum8
                        || code == shadow.code_sum16)
                    code = code + 4'd1;
            end
        endcase

        type_byte = {code, 4'($urandom)};
        frame = {shadow.sync_first_byte, shadow.sync_second_byte, type_byte,
                 flen[15:8], flen[7:0]};
        total = 16'(frame[2]) + 16'(frame[3]) + 16'(frame[4]);
        n_pay = (len > HEADER_BYTES + ck) ? len - HEADER_BYTES - ck : 0;
        for (int i = 0; i < n_pay; i++) begin
            case (pat)
                PAY_ZERO: p = 8'h00;
                PAY_ONES: p = 8'hFF;
                PAY_SYNC: p = i[0] ? shadow.sync_second_byte : shadow.sync_first_byte;
                default:  p = 8'($urandom);
            endcase
            frame.push_back(p);
            total = total + p;
        end
        if (ck == 1) frame.push_back(total[7:0] ^ flip);
        if (ck == 2) begin
            frame.push_back(total[15:8] ^ flip);
            frame.push_back(total[7:0]);
        end
        for (int i = 0; i < frame.size() && i < keep; i++)
            tx_q.push_back(frame[i]);
    endtask

    // Mostly well-formed packets with random content, plus broken headers, cut-off
    // packets, false starts and noise. Only well-formed packet bytes are counted.
    task automatic random_traffic(input int unsigned n);
        int unsigned sent;
        int unsigned lo;
        int unsigned hi;
        int unsigned len;
        int unsigned bad;
        int unsigned r;
        check_kind_t k;

        sent = 0;
        while (sent < n) begin
            r  = $urandom_range(0, 99);
            k  = check_kind_t'($urandom_range(CK_NONE, CK_SUM16));
            lo = (shadow.min_packet_len > 7) ? shadow.min_packet_len : 7;
            hi = (shadow.max_packet_len < lo + 40) ? shadow.max_packet_len : lo + 40;
            len = $urandom_range(lo, hi);
            if (r < 70) begin
                add_frame(k, len, $urandom_range(0, 3) == 0, PAY_RANDOM, len);
                sent += len;
            end else if (r < 76) begin
                add_frame(CK_UNKNOWN, len, 1'b0, PAY_RANDOM, HEADER_BYTES);
            end else if (r < 82) begin
                bad = ($urandom_range(0, 1) && shadow.max_packet_len < 16'hFFFF)
                    ? $urandom_range(shadow.max_packet_len + 1, 16'hFFFF)
                    : $urandom_range(0, HEADER_BYTES);
                add_frame(k, bad, 1'b0, PAY_RANDOM, HEADER_BYTES);
            end else if (r < 88) begin
                add_frame(k, len, 1'b0, PAY_RANDOM, $urandom_range(1, len - 1));
            end else if (r < 94) begin
                tx_q.push_back(shadow.sync_first_byte);
                tx_q.push_back($urandom_range(0, 1) ? shadow.sync_first_byte : 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 8)) tx_q.push_back(8'($urandom));
            end
            send_all();
        end
    endtask

    initial begin : stimulus
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        burst_left = 0;
        hold_req   = 0;
        shadow = '{sync_first_byte: RST_SYNC_FIRST, sync_second_byte: RST_SYNC_SECOND,
                   min_packet_len: RST_MIN_LEN, max_packet_len: RST_MAX_LEN,
                   code_no_check: RST_CODE_NONE, code_sum8: RST_CODE_SUM8,
                   code_sum16: RST_CODE_SUM16};
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // Directed cases at the reset configuration.
        add_frame(CK_NONE, 6, 1'b0, PAY_ZERO, 6);
        add_frame(CK_SUM8, 6, 1'b0, PAY_RANDOM, 6);          // empty message
        add_frame(CK_SUM16, 7, 1'b0, PAY_RANDOM, 7);         // empty message
        add_frame(CK_SUM8, 12, 1'b1, PAY_ONES, 12);          // bad 8-bit sum
        add_frame(CK_SUM16, 12, 1'b1, PAY_ONES, 12);         // bad 16-bit sum
        add_frame(CK_NONE, 14, 1'b0, PAY_SYNC, 14);          // sync values as payload
        add_frame(CK_UNKNOWN, 10, 1'b0, PAY_RANDOM, HEADER_BYTES);
        add_frame(CK_SUM8, 5, 1'b0, PAY_RANDOM, HEADER_BYTES);       // below minimum
        add_frame(CK_NONE, 1024, 1'b0, PAY_RANDOM, HEADER_BYTES);    // above maximum
        add_frame(CK_SUM16, 6, 1'b0, PAY_RANDOM, HEADER_BYTES);      // no room for check
        tx_q.push_back(shadow.sync_first_byte);                      // repeated first sync
        add_frame(CK_SUM8, 9, 1'b0, PAY_RANDOM, 9);
        tx_q.push_back(shadow.sync_first_byte);                      // false start
        tx_q.push_back(8'h00);
        add_frame(CK_SUM16, 20, 1'b0, PAY_ONES, 20);
        send_all();

        // A long packet while the receiver holds off, so the input backs up.
        quiesce();
        hold_req++;
        burst_left = 2000;
        add_frame(CK_SUM16, LONG_FRAME, 1'b0, PAY_RANDOM, LONG_FRAME);
        send_all();

        // Extreme sync values, widest length window, extreme type codes.
        quiesce();
        set_reg(REG_SYNC_FIRST, 16'h0000);
        set_reg(REG_SYNC_SECOND, 16'h00FF);
        set_reg(REG_MAX_LEN, 16'hFFFF);
        set_reg(REG_CODE_NONE, 16'h000F);
        set_reg(REG_CODE_SUM8, 16'h0000);
        set_reg(REG_CODE_SUM16, 16'h0007);
        random_traffic(RANDOM_BYTES);

        // Equal sync values never frame a packet.
        quiesce();
        set_reg(REG_SYNC_FIRST, 16'h003C);
        set_reg(REG_SYNC_SECOND, 16'h003C);
        add_frame(CK_NONE, 10, 1'b0, PAY_RANDOM, 10);
        send_all();

        // Equal type codes, and a length window of a single value.
        quiesce();
        set_reg(REG_SYNC_SECOND, 16'h00C3);
        set_reg(REG_CODE_NONE, 16'h0005);
        set_reg(REG_CODE_SUM8, 16'h0005);
        set_reg(REG_CODE_SUM16, 16'h0009);
        set_reg(REG_MIN_LEN, 16'd20);
        set_reg(REG_MAX_LEN, 16'd20);
        add_frame(CK_NONE, 20, 1'b0, PAY_RANDOM, 20);
        add_frame(CK_SUM8, 20, 1'b0, PAY_RANDOM, 20);        // taken as no check
        add_frame(CK_SUM16, 19, 1'b0, PAY_RANDOM, HEADER_BYTES);
        add_frame(CK_SUM16, 21, 1'b0, PAY_RANDOM, HEADER_BYTES);
        send_all();
        random_traffic(RANDOM_BYTES);

        // Length limits at their extremes.
        quiesce();
        set_reg(REG_MAX_LEN, 16'hFFFF);
        set_reg(REG_MIN_LEN, 16'hFFFF);
        add_frame(CK_NONE, 16'hFFFE, 1'b0, PAY_RANDOM, HEADER_BYTES);
        add_frame(CK_SUM8, 6, 1'b0, PAY_RANDOM, HEADER_BYTES);
        send_all();
        quiesce();
        set_reg(REG_MIN_LEN, 16'd6);
        set_reg(REG_MAX_LEN, 16'd6);
        add_frame(CK_NONE, 6, 1'b0, PAY_ONES, 6);
        add_frame(CK_SUM8, 6, 1'b1, PAY_RANDOM, 6);
        add_frame(CK_SUM16, 6, 1'b0, PAY_RANDOM, HEADER_BYTES);
        add_frame(CK_NONE, 7, 1'b0, PAY_RANDOM, HEADER_BYTES);
        send_all();

        // Back to the reset values for the last random stretch.
        quiesce();
        set_reg(REG_SYNC_FIRST, 16'(RST_SYNC_FIRST));
        set_reg(REG_SYNC_SECOND, 16'(RST_SYNC_SECOND));
        set_reg(REG_MIN_LEN, RST_MIN_LEN);
        set_reg(REG_MAX_LEN, RST_MAX_LEN);
        set_reg(REG_CODE_NONE, 16'(RST_CODE_NONE));
        set_reg(REG_CODE_SUM8, 16'(RST_CODE_SUM8));
        set_reg(REG_CODE_SUM16, 16'(RST_CODE_SUM16));
        random_traffic(RANDOM_BYTES);

        quiesce();
        if (fail_count == 0 && results_due == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sfpd_pkg.sv
hw/rtl/sfpd_cfg_regs.sv
hw/rtl/sfpd_core.sv
hw/rtl/sync_framed_packet_deframer.sv
tb/sfpd_deframe_checker.sv
tb/sync_framed_packet_deframer_tb.sv
